/* rtl/dts_pkg.sv */
// Shared types and constants for the delimiter token splitter.
// Holds configuration register indexes and fixed field widths; no dependencies.
package dts_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int DLEN_W     = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_W      = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_LENGTH = 1'b0,
        CFG_DELIM_BYTES  = 1'b1
    } t_cfg_index;

endpackage

/* rtl/delimiter_token_splitter.sv */
// Delimiter token splitter top level: byte window, delimiter compare, token result register.
// Depends on dts_pkg for field widths and configuration register indexes.

// Takes one source byte per cycle and splits the string on a programmable delimiter of one to
// MAX_DELIMITER bytes. Each byte is handled in a single registered pass: the delimiter compare
// against the last MAX_DELIMITER bytes runs in parallel in the same cycle the byte transfers,
// and the token (start index, length, overflow) is loaded into the result register. The block
// sustains one byte per cycle; results appear in the cycle after the byte that completes a
// delimiter or carries end_of_source. The result register is the only stage between the two
// sides, so input ready falls only while a result is held and the output side is not ready.
// Program the delimiter only while no string is in progress and no result is pending.
module delimiter_token_splitter #(
    parameter int MAX_DELIMITER = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Byte input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dts_pkg::BYTE_W-1:0]         i_byte_value,
    input  logic                               i_end_of_source,
    // Token output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dts_pkg::OUT_W-1:0]          o_token_start_index,
    output logic [dts_pkg::OUT_W-1:0]          o_token_length,
    output logic                               o_overflow
);

    localparam int LP_WIN_W = dts_pkg::BYTE_W * MAX_DELIMITER;
    localparam int LP_DIFF_W = POSITION_BITS + 1;
    localparam int LP_EXT_W = (LP_DIFF_W > dts_pkg::OUT_W) ? LP_DIFF_W : dts_pkg::OUT_W;
    localparam logic [POSITION_BITS-1:0] LP_PMAX = '1;
    localparam logic [dts_pkg::DLEN_W-1:0] LP_MAX_LEN = dts_pkg::DLEN_W'(MAX_DELIMITER);

    // Configuration registers
    logic [dts_pkg::DLEN_W-1:0] r_dlen;
    logic [LP_WIN_W-1:0]        r_dbytes;

    // Per-string state
    logic [LP_WIN_W-1:0]      r_win;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_seg;
    logic                     r_ovf;

    // Result register
    logic                       r_out_valid;
    logic [dts_pkg::OUT_W-1:0]  r_start;
    logic [dts_pkg::OUT_W-1:0]  r_len;
    logic                       r_out_ovf;

    logic                       w_in_xfer;
    logic [LP_WIN_W-1:0]        w_win;
    logic [dts_pkg::DLEN_W-1:0] w_n;
    logic [MAX_DELIMITER-1:0]   w_match_k;
    logic                       w_match;
    logic [LP_DIFF_W-1:0]       w_next;
    logic                       w_sat;
    logic [POSITION_BITS-1:0]   w_pos_new;
    logic [LP_DIFF_W-1:0]       w_diff;
    logic                       w_hit;
    logic                       w_emit;
    logic [LP_DIFF_W-1:0]       w_len;
    logic [LP_EXT_W-1:0]        w_len_ext;
    logic [LP_EXT_W-1:0]        w_start_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen   <= dts_pkg::DLEN_W'(1);
            r_dbytes <= LP_WIN_W'(44);
        end else if (i_cfg_valid) begin
            unique case (dts_pkg::t_cfg_index'(i_cfg_index))
                dts_pkg::CFG_DELIM_LENGTH: r_dlen   <= i_cfg_data[dts_pkg::DLEN_W-1:0];
                dts_pkg::CFG_DELIM_BYTES:  r_dbytes <= i_cfg_data[LP_WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Shift the new byte into the window, newest byte lowest
    assign w_win = LP_WIN_W'({r_win, i_byte_value});

    // Clamp the delimiter length into 1..MAX_DELIMITER
    always_comb begin
        if (r_dlen == '0) begin
            w_n = dts_pkg::DLEN_W'(1);
        end else if (r_dlen > LP_MAX_LEN) begin
            w_n = LP_MAX_LEN;
        end else begin
            w_n = r_dlen;
        end
    end

    // Compare the window against the delimiter for every candidate length in parallel
    always_comb begin
        for (int k = 1; k <= MAX_DELIMITER; k++) begin
            w_match_k[k-1] = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (r_dbytes[dts_pkg::BYTE_W*i +: dts_pkg::BYTE_W] !=
                    w_win[dts_pkg::BYTE_W*(k-1-i) +: dts_pkg::BYTE_W]) begin
                    w_match_k[k-1] = 1'b0;
                end
            end
        end
    end

    // Pick the compare result for the configured length
    always_comb begin
        w_match = 1'b0;
        for (int k = 1; k <= MAX_DELIMITER; k++) begin
            if (w_n == dts_pkg::DLEN_W'(k)) begin
                w_match = w_match_k[k-1];
            end
        end
    end

    // Advance the position with saturation
    assign w_next    = {1'b0, r_pos} + LP_DIFF_W'(1);
    assign w_sat     = w_next[POSITION_BITS];
    assign w_pos_new = w_sat ? LP_PMAX : w_next[POSITION_BITS-1:0];

    // Delimiter must lie wholly inside the current segment
    assign w_diff = w_next - {1'b0, r_seg};
    assign w_hit  = w_match && (w_diff >= LP_DIFF_W'(w_n));
    assign w_emit = w_hit || i_end_of_source;
    assign w_len  = w_hit ? (w_diff - LP_DIFF_W'(w_n)) : w_diff;

    assign w_len_ext   = LP_EXT_W'(w_len);
    assign w_start_ext = LP_EXT_W'(r_seg);

    // Update per-string state; end of source returns it to the reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_pos <= '0;
            r_seg <= '0;
            r_ovf <= 1'b0;
        end else if (w_in_xfer) begin
            if (i_end_of_source) begin
                r_win <= '0;
                r_pos <= '0;
                r_seg <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_win <= w_win;
                r_pos <= w_pos_new;
                r_ovf <= r_ovf || w_sat;
                if (w_hit) begin
                    r_seg <= w_pos_new;
                end
            end
        end
    end

    // Hold the result until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the token payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_emit) begin
            r_start   <= w_start_ext[dts_pkg::OUT_W-1:0];
            r_len     <= w_len_ext[dts_pkg::OUT_W-1:0];
            r_out_ovf <= r_ovf || w_sat;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_token_start_index = r_start;
    assign o_token_length      = r_len;
    assign o_overflow          = r_out_ovf;

    // Segment start never runs ahead of the byte position
    a_seg_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg <= r_pos)
        else $error("segment start ahead of byte position");

    // Sticky overflow implies the position sits at its bound
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_pos == LP_PMAX))
        else $error("overflow set without saturated position");

    // The last byte of a string always yields a token
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_end_of_source) |=> o_out_valid)
        else $error("end of source produced no token");

    // No result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for delimiter_token_splitter: random and directed byte strings
// against a cycle-free token predictor, with bursty input and a stalling token sink.
// Depends on dts_pkg and the delimiter_token_splitter RTL.
module tb_top;

    localparam logic [16:0] POS_MAX       = 17'h0FFFF;
    localparam int          RANDOM_BYTES  = 1450;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 4;

    // Token predictor and store of expected tokens
    class token_scoreboard;
        typedef struct packed {
            logic [dts_pkg::OUT_W-1:0] start;
            logic [dts_pkg::OUT_W-1:0] length;
            logic                      ovf;
        } t_token;

        t_token      expected_tokens[$];
        logic [3:0]  delim_len_reg;
        logic [63:0] delim_pat_reg;
        logic [63:0] window;
        logic [16:0] position;
        logic [16:0] seg_start;
        logic        ovf_seen;
        int          errors;
        int          tokens_checked;
        int          bytes_seen;
        int          strings_seen;

        function new();
            delim_len_reg  = 4'd1;
            delim_pat_reg  = 64'd44;
            errors         = 0;
            tokens_checked = 0;
            bytes_seen     = 0;
            strings_seen   = 0;
            clear_string();
        endfunction

        function void clear_string();
            window    = '0;
            position  = '0;
            seg_start = '0;
            ovf_seen  = 1'b0;
        endfunction

        function void write_register(dts_pkg::t_cfg_index idx,
                                     logic [dts_pkg::CFG_DATA_W-1:0] data);
            if (idx == dts_pkg::CFG_DELIM_LENGTH) begin
                delim_len_reg = data[3:0];
            end else begin
                delim_pat_reg = data;
            end
        endfunction

        // Advance the string state by one byte and queue the token it ends, if any
        function void note_byte(logic [dts_pkg::BYTE_W-1:0] b, logic eos);
            int unsigned n;
            logic [16:0] nxt;
            logic [16:0] seg;
            logic        hit;
            logic        emit;
            t_token      t;
            n = (delim_len_reg == 4'd0) ? 1 : ((delim_len_reg > 4'd8) ? 8 : delim_len_reg);
            bytes_seen++;
            window = {window[55:0], b};
            nxt    = position + 17'd1;
            seg    = seg_start;
            if (nxt > POS_MAX) begin
                ovf_seen = 1'b1;
                position = POS_MAX;
            end else begin
                position = nxt;
            end
            // Delimiter must complete on this byte and lie wholly inside the segment
            hit = (nxt >= seg) && ((nxt - seg) >= n);
            for (int i = 0; i < 8; i++) begin
                if (i < n) begin
                    if (delim_pat_reg[8*i +: 8] != window[8*(n-1-i) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            emit = 1'b0;
            t    = '0;
            if (hit) begin
                emit      = 1'b1;
                t.start   = seg[15:0];
                t.length  = 16'(nxt - n - seg);
                seg_start = (nxt > POS_MAX) ? POS_MAX : nxt;
            end else if (eos) begin
                emit     = 1'b1;
                t.start  = seg[15:0];
                t.length = (nxt >= seg) ? 16'(nxt - seg) : 16'd0;
            end
            t.ovf = ovf_seen;
            if (emit) begin
                expected_tokens.push_back(t);
            end
            if (eos) begin
                strings_seen++;
                clear_string();
            end
        endfunction

        function void check_token(logic [dts_pkg::OUT_W-1:0] s, logic [dts_pkg::OUT_W-1:0] l,
                                  logic o);
            t_token t;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: token with none expected: start %0d length %0d overflow %0d",
                         $time, s, l, o);
                return;
            end
            t = expected_tokens.pop_front();
            tokens_checked++;
            if (s !== t.start) begin
                errors++;
                $display("%0t: token_start_index expected %0d actual %0d", $time, t.start, s);
            end
            if (l !== t.length) begin
                errors++;
                $display("%0t: token_length expected %0d actual %0d", $time, t.length, l);
            end
            if (o !== t.ovf) begin
                errors++;
                $display("%0t: overflow expected %0d actual %0d", $time, t.ovf, o);
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [dts_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dts_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [dts_pkg::BYTE_W-1:0]     i_byte_value;
    logic                           i_end_of_source;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [dts_pkg::OUT_W-1:0]      o_token_start_index;
    logic [dts_pkg::OUT_W-1:0]      o_token_length;
    logic                           o_overflow;

    token_scoreboard sb = new();

    logic [dts_pkg::BYTE_W-1:0] text_buf[$];
    logic [63:0]                gen_pat;
    int                         gen_n;
    bit                         gaps_on;
    bit                         hold_request;
    int                         burst_left;
    int                         settings_count;
    int                         long_holds;

    delimiter_token_splitter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_byte_value        (i_byte_value),
        .i_end_of_source     (i_end_of_source),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_token_start_index (o_token_start_index),
        .o_token_length      (o_token_length),
        .o_overflow          (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Note input transfers before checking output transfers, so a token is queued before it can be checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_register(dts_pkg::t_cfg_index'(i_cfg_index), i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_byte_value, i_end_of_source);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_token(o_token_start_index, o_token_length, o_overflow);
            end
        end
    end

    // Token sink: stretches of different stall patterns, plus long hold-offs on request
    initial begin
        int mode;
        int span;
        int period;
        i_out_ready <= 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else begin
                mode   = $urandom_range(0, 3);
                span   = $urandom_range(16, 120);
                period = $urandom_range(2, 8);
                for (int k = 0; k < span && !hold_request; k++) begin
                    @(posedge i_clk);
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        2:       i_out_ready <= ((k % period) == 0);
                        default: i_out_ready <= ($urandom_range(0, 9) != 0);
                    endcase
                end
            end
        end
    end

    task automatic wait_cfg_transfer();
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write both delimiter registers back to back; upper bits of the length word are noise
    task automatic program_delimiter(logic [3:0] len_code, logic [63:0] pattern);
        logic [63:0] len_word;
        len_word      = {$urandom, $urandom};
        len_word[3:0] = len_code;
        gen_n         = (len_code == 4'd0) ? 1 : ((len_code > 4'd8) ? 8 : len_code);
        gen_pat       = pattern;
        settings_count++;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= dts_pkg::CFG_DELIM_LENGTH;
        i_cfg_data  <= len_word;
        wait_cfg_transfer();
        i_cfg_index <= dts_pkg::CFG_DELIM_BYTES;
        i_cfg_data  <= pattern;
        wait_cfg_transfer();
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one byte, hold it until transfer, then maybe open a gap between bursts
    task automatic send_byte(logic [dts_pkg::BYTE_W-1:0] b, logic eos);
        i_in_valid      <= 1'b1;
        i_byte_value    <= b;
        i_end_of_source <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_byte(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    task automatic send_literal(string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) begin
            text_buf.push_back(s[k]);
        end
        send_text();
    endtask

    // Drop valid, wait for every expected token, then let the pipeline settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Build one string from whole delimiters, broken delimiters and noise
    task automatic build_string(int max_len);
        int target;
        int roll;
        int cut;
        text_buf.delete();
        target = $urandom_range(1, max_len);
        while (text_buf.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                for (int i = 0; i < gen_n; i++) text_buf.push_back(gen_pat[8*i +: 8]);
            end else if (roll < 40 && gen_n > 1) begin
                cut = $urandom_range(1, gen_n - 1);
                for (int i = 0; i < cut; i++) text_buf.push_back(gen_pat[8*i +: 8]);
            end else if (roll < 70) begin
                text_buf.push_back(gen_pat[8*$urandom_range(0, gen_n - 1) +: 8]);
            end else begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int          random_bytes;
        int          phase;
        int          phase_bytes;
        int          phase_target;
        logic [3:0]  len_code;
        logic [63:0] pattern;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= dts_pkg::CFG_DELIM_LENGTH;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_byte_value    <= '0;
        i_end_of_source <= 1'b0;
        hold_request   = 1'b0;
        gaps_on        = 1'b1;
        burst_left     = 0;
        settings_count = 1;
        long_holds     = 0;
        gen_n          = 1;
        gen_pat        = 64'd44;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset delimiter is a single comma
        send_literal("a,b");
        send_literal(",,x");
        send_literal("ab,");
        send_literal(",");
        text_buf = '{8'h00, 8'hFF};
        send_text();

        // Length code zero behaves as one
        settle();
        program_delimiter(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        text_buf = '{8'hFF, 8'h00, 8'hFF};
        send_text();

        // Length code above eight behaves as eight
        settle();
        program_delimiter(4'd15, 64'h8877_6655_4433_2211);
        text_buf = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h7A};
        send_text();

        // Random phases, each under a fresh delimiter setting
        random_bytes = 0;
        phase        = 0;
        while (random_bytes < RANDOM_BYTES) begin
            case ($urandom_range(0, 5))
                0:       len_code = 4'd0;
                1:       len_code = 4'd15;
                2:       len_code = 4'($urandom_range(9, 14));
                default: len_code = 4'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: pattern = {8{8'($urandom_range(0, 255))}};
                3, 4:    begin
                    for (int i = 0; i < 8; i++) begin
                        pattern[8*i +: 8] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
                    end
                end
                default: pattern = {$urandom, $urandom};
            endcase
            if (phase == 1) begin
                len_code = 4'd1;
            end
            settle();
            program_delimiter(len_code, pattern);
            gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            // Hold the sink off while dense delimiters keep arriving
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            phase_target = $urandom_range(80, 180);
            phase_bytes  = 0;
            while (phase_bytes < phase_target) begin
                build_string((phase == 1) ? 60 : 40);
                send_text();
                phase_bytes += text_buf.size();
            end
            random_bytes += phase_bytes;
            phase++;
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d bytes in %0d strings, %0d tokens checked", sb.bytes_seen,
                 sb.strings_seen, sb.tokens_checked);
        $display("tb_top: %0d delimiter settings, %0d long sink hold-offs",
                 settings_count, long_holds);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
